// ===== design/itrd_pkg.sv =====
// ----------------------------------------------------------------------------
// itrd_pkg - shared definitions for the integer to radix digit converter
// Sizes, ASCII constants, radix saturation and the divider result group.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 64;

  // Divider consumes this many dividend bits per cycle
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int DIV_W         = DIV_STEPS * BITS_PER_STEP;
  localparam int STEP_W        = $clog2(DIV_STEPS + 1);

  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;
  localparam int ADDR_W  = $clog2(MAX_DIGITS);
  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);

  localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] DIGIT_ZERO = 7'd48;       // '0'
  localparam logic [CHAR_W-1:0] LOWER_BASE = 7'd87;       // 'a' - 10
  localparam logic [CHAR_W-1:0] UPPER_BASE = 7'd55;       // 'A' - 10

  localparam logic [7:0] REG_RADIX      = 8'd0;
  localparam logic [7:0] REG_UPPER_CASE = 8'd1;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_res_t;

  function automatic logic [DIGIT_W-1:0] eff_radix(input logic [DIGIT_W-1:0] r);
    logic [DIGIT_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                      input logic upper);
    logic [CHAR_W-1:0] res;
    if (d < 6'd10) begin
      res = DIGIT_ZERO + CHAR_W'(d);
    end else if (upper) begin
      res = UPPER_BASE + CHAR_W'(d);
    end else begin
      res = LOWER_BASE + CHAR_W'(d);
    end
    return res;
  endfunction

endpackage

// ===== design/itrd_div.sv =====
// ----------------------------------------------------------------------------
// itrd_div - iterative divider by a small radix
// Restoring long division, BITS_PER_STEP quotient bits per cycle.
// ----------------------------------------------------------------------------
module itrd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [itrd_pkg::DIV_W-1:0]   dividend,
  input  logic [itrd_pkg::DIGIT_W-1:0] divisor,
  output itrd_pkg::div_res_t           res
);
  import itrd_pkg::*;

  logic               busy;
  logic               done;
  logic [STEP_W-1:0]  steps;
  logic [DIV_W-1:0]   work;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] dvsr;

  logic [DIV_W-1:0]   work_next;
  logic [DIGIT_W-1:0] rem_next;

  // Shift dividend bits out at the top, quotient bits in at the bottom
  always_comb begin
    logic [DIGIT_W:0] r;
    r = {1'b0, rem};
    work_next = work;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      r = {r[DIGIT_W-1:0], work_next[DIV_W-1]};
      work_next = {work_next[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, dvsr}) begin
        r = r - {1'b0, dvsr};
        work_next[0] = 1'b1;
      end
    end
    rem_next = r[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_STEPS - 1);
        work  <= dividend;
        rem   <= '0;
        dvsr  <= divisor;
      end else if (busy) begin
        work  <= work_next;
        rem   <= rem_next;
        steps <= steps - 1'b1;
        if (steps == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done      = done;
  assign res.quotient  = work;
  assign res.remainder = rem;

endmodule

// ===== design/itrd_store.sv =====
// ----------------------------------------------------------------------------
// itrd_store - digit memory
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module itrd_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [itrd_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [itrd_pkg::DIGIT_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [itrd_pkg::ADDR_W-1:0]  rd_addr,
  output logic [itrd_pkg::DIGIT_W-1:0] rd_data
);
  import itrd_pkg::*;

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits - unsigned integer to ASCII digits in a set radix
// Divides the value by the radix repeatedly, stores the remainders and
// streams them out as characters, most significant digit first.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  s_axis   | in  | tdata[63:0] value
//  m_axis   | out | tdata[6:0] digit_char, tdata[7] zero; tlast = last digit
//  cfg      | in  | index 0 radix (data[5:0]), index 1 upper_case (data[0])
//
//  Timing: each digit is divided out in the shared divider, which takes
//  one 8-bit slice of the dividend per cycle while busy; on output each
//  digit passes through the EMIT_RD, EMIT_LD and EMIT_SH states and the
//  memory read port, so a word is divided fully before its first digit.
//  Reset: synchronous; radix returns to 10, upper_case to 0.
//  Stalls: the output register holds a digit until taken; a new value is
//  taken only once the last digit of the previous one has left.
module integer_to_radix_digits (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] digit_char, [7] zero pad
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import itrd_pkg::*;

  typedef enum logic [2:0] {
    IDLE, DIV_START, DIV_WAIT, EMIT_RD, EMIT_LD, EMIT_SH
  } state_t;

  state_t             state;
  logic [DIGIT_W-1:0] radix;
  logic               upper_case;
  logic [VALUE_WIDTH-1:0] remaining_value;
  logic [CNT_W-1:0]   digit_count;
  logic [CNT_W-1:0]   emit_cnt;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;
  logic               out_valid;

  div_res_t           div_res;
  logic               div_start;
  logic               wr_en;
  logic               rd_en;
  logic [DIGIT_W-1:0] rd_data;
  logic [CNT_W-1:0]   count_next;
  logic [VALUE_WIDTH-1:0] quot;

  assign s_axis_tready = (state == IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_char};
  assign m_axis_tlast  = out_last;

  assign div_start  = (state == DIV_START);
  assign wr_en      = (state == DIV_WAIT) && div_res.done;
  assign rd_en      = (state == EMIT_RD);
  assign count_next = digit_count + 1'b1;
  assign quot       = div_res.quotient[VALUE_WIDTH-1:0];

  itrd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIV_W'(remaining_value)),
    .divisor  (eff_radix(radix)),
    .res      (div_res)
  );

  itrd_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (digit_count[ADDR_W-1:0]),
    .wr_data (div_res.remainder),
    .rd_en   (rd_en),
    .rd_addr (ADDR_W'(emit_cnt - 1'b1)),
    .rd_data (rd_data)
  );

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= RADIX_RESET;
      upper_case <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIX:      radix      <= cfg_data[DIGIT_W-1:0];
        REG_UPPER_CASE: upper_case <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: divide until the quotient runs out or the store fills,
  // then read digits back from the top entry down
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      remaining_value <= '0;
      digit_count     <= '0;
      emit_cnt        <= '0;
      out_valid       <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            remaining_value <= s_axis_tdata[VALUE_WIDTH-1:0];
            digit_count     <= '0;
            state           <= DIV_START;
          end
        end
        DIV_START: begin
          state <= DIV_WAIT;
        end
        DIV_WAIT: begin
          if (div_res.done) begin
            remaining_value <= quot;
            digit_count     <= count_next;
            if ((quot == '0) || (count_next == CNT_W'(MAX_DIGITS))) begin
              emit_cnt <= count_next;
              state    <= EMIT_RD;
            end else begin
              state <= DIV_START;
            end
          end
        end
        EMIT_RD: begin
          state <= EMIT_LD;
        end
        EMIT_LD: begin
          out_valid <= 1'b1;
          out_char  <= digit_to_ascii(rd_data, upper_case);
          out_last  <= (emit_cnt == CNT_W'(1));
          state     <= EMIT_SH;
        end
        EMIT_SH: begin
          // Hold the word until the sink takes it
          if (m_axis_tready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= IDLE;
            end else begin
              emit_cnt <= emit_cnt - 1'b1;
              state    <= EMIT_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== design/itrd_checker.sv =====
// ----------------------------------------------------------------------------
// itrd_checker - port level checks for the digit converter
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module itrd_props (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  // Stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // Input side opens only with no digit pending
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a digit is pending");

  // Characters stay within '0'..'z'
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata >= 8'd48) && (m_axis_tdata <= 8'd122))
    else $error("digit character out of range");

  // Final digit taken returns the block to accepting input
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("not ready after final digit");

endmodule

bind integer_to_radix_digits itrd_props u_itrd_props (.*);
